/* sv/lpfp_pkg.sv */
package lpfp_pkg;

   localparam int unsigned LEN_W  = 32;
   localparam int unsigned BYTE_W = 8;

   typedef logic [1:0] kind_type;

   localparam kind_type KIND_PAYLOAD   = 2'd0;
   localparam kind_type KIND_EMPTY     = 2'd1;
   localparam kind_type KIND_HEARTBEAT = 2'd2;
   localparam kind_type KIND_OVERSIZE  = 2'd3;

   localparam logic CMD_BYTE     = 1'b0;
   localparam logic CMD_NEW_CONN = 1'b1;

   localparam logic CSR_LEN_LIMIT      = 1'b0;
   localparam logic CSR_HEARTBEAT_TYPE = 1'b1;

   localparam logic PHASE_HEADER  = 1'b0;
   localparam logic PHASE_PAYLOAD = 1'b1;

   localparam logic [LEN_W-1:0]  LEN_LIMIT_RESET      = 32'd65536;
   localparam logic [BYTE_W-1:0] HEARTBEAT_TYPE_RESET = 8'd0;
   localparam logic [2:0]        HEADER_LEN_BYTES     = 3'd4;
   localparam logic [LEN_W-1:0]  NODE_ID_BYTES        = 32'd4;

   typedef struct packed {
      logic              command;
      logic [BYTE_W-1:0] rx_byte;
   } item_type;

   typedef struct packed {
      kind_type          kind;
      logic [BYTE_W-1:0] frame_type;
      logic [BYTE_W-1:0] data_byte;
      logic [LEN_W-1:0]  node_id;
      logic [LEN_W-1:0]  frame_length;
      logic              last;
   } result_type;

endpackage

/* sv/lpfp_parse.sv */
module lpfp_parse (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic                               csr_index,
   input  logic [lpfp_pkg::LEN_W-1:0]         csr_wdata,
   input  logic                               step,
   input  lpfp_pkg::item_type                 item,
   output logic                               emit,
   output lpfp_pkg::result_type               result
);

   logic [lpfp_pkg::LEN_W-1:0]  len_limit_ff, len_limit_in;
   logic [lpfp_pkg::BYTE_W-1:0] heartbeat_type_ff, heartbeat_type_in;

   logic                        phase_ff, phase_in;
   logic [2:0]                  header_count_ff, header_count_in;
   logic [lpfp_pkg::LEN_W-1:0]  length_reg_ff, length_reg_in;
   logic [lpfp_pkg::BYTE_W-1:0] type_reg_ff, type_reg_in;
   logic [lpfp_pkg::LEN_W-1:0]  payload_count_ff, payload_count_in;
   logic [lpfp_pkg::LEN_W-1:0]  node_accum_ff, node_accum_in;
   logic                        dropped_ff, dropped_in;

   always_comb begin
      len_limit_in      = len_limit_ff;
      heartbeat_type_in = heartbeat_type_ff;
      if (csr_we) begin
         unique case (csr_index)
            lpfp_pkg::CSR_LEN_LIMIT:      len_limit_in = csr_wdata;
            lpfp_pkg::CSR_HEARTBEAT_TYPE:
               heartbeat_type_in = csr_wdata[lpfp_pkg::BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in         = phase_ff;
      header_count_in  = header_count_ff;
      length_reg_in    = length_reg_ff;
      type_reg_in      = type_reg_ff;
      payload_count_in = payload_count_ff;
      node_accum_in    = node_accum_ff;
      dropped_in       = dropped_ff;
      emit             = 1'b0;
      result.kind      = lpfp_pkg::KIND_PAYLOAD;
      result.data_byte = '0;
      result.node_id   = '0;
      result.last      = 1'b1;

      if (step) begin
         if (item.command == lpfp_pkg::CMD_NEW_CONN) begin
            phase_in         = lpfp_pkg::PHASE_HEADER;
            header_count_in  = '0;
            length_reg_in    = '0;
            type_reg_in      = '0;
            payload_count_in = '0;
            node_accum_in    = '0;
            dropped_in       = 1'b0;
         end else if (!dropped_ff) begin
            if (phase_ff == lpfp_pkg::PHASE_HEADER) begin
               if (header_count_ff != lpfp_pkg::HEADER_LEN_BYTES) begin
                  if (header_count_ff == 3'd0) begin
                     length_reg_in = '0;
                  end
                  length_reg_in[{header_count_ff[1:0], 3'b000} +: 8] = item.rx_byte;
                  header_count_in = header_count_ff + 3'd1;
               end else begin
                  type_reg_in      = item.rx_byte;
                  header_count_in  = '0;
                  payload_count_in = '0;
                  node_accum_in    = '0;
                  if (length_reg_ff > len_limit_ff) begin
                     dropped_in  = 1'b1;
                     emit        = 1'b1;
                     result.kind = lpfp_pkg::KIND_OVERSIZE;
                  end else if (length_reg_ff == '0) begin
                     emit = 1'b1;
                     if (item.rx_byte == heartbeat_type_ff) begin
                        result.kind = lpfp_pkg::KIND_HEARTBEAT;
                     end else begin
                        result.kind = lpfp_pkg::KIND_EMPTY;
                     end
                  end else begin
                     phase_in = lpfp_pkg::PHASE_PAYLOAD;
                  end
               end
            end else begin
               if (payload_count_ff < lpfp_pkg::NODE_ID_BYTES) begin
                  node_accum_in[{payload_count_ff[1:0], 3'b000} +: 8] = item.rx_byte;
               end
               payload_count_in = payload_count_ff + 32'd1;
               if (payload_count_in >= length_reg_ff) begin
                  phase_in = lpfp_pkg::PHASE_HEADER;
                  emit     = 1'b1;
                  if (type_reg_ff == heartbeat_type_ff) begin
                     result.kind = lpfp_pkg::KIND_HEARTBEAT;
                     if (length_reg_ff >= lpfp_pkg::NODE_ID_BYTES) begin
                        result.node_id = node_accum_in;
                     end
                  end else begin
                     result.data_byte = item.rx_byte;
                  end
               end else if (type_reg_ff != heartbeat_type_ff) begin
                  emit             = 1'b1;
                  result.data_byte = item.rx_byte;
                  result.last      = 1'b0;
               end
            end
         end
      end

      result.frame_type   = type_reg_in;
      result.frame_length = length_reg_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_limit_ff      <= lpfp_pkg::LEN_LIMIT_RESET;
         heartbeat_type_ff <= lpfp_pkg::HEARTBEAT_TYPE_RESET;
         phase_ff          <= lpfp_pkg::PHASE_HEADER;
         header_count_ff   <= '0;
         length_reg_ff     <= '0;
         type_reg_ff       <= '0;
         payload_count_ff  <= '0;
         node_accum_ff     <= '0;
         dropped_ff        <= 1'b0;
      end else begin
         len_limit_ff      <= len_limit_in;
         heartbeat_type_ff <= heartbeat_type_in;
         phase_ff          <= phase_in;
         header_count_ff   <= header_count_in;
         length_reg_ff     <= length_reg_in;
         type_reg_ff       <= type_reg_in;
         payload_count_ff  <= payload_count_in;
         node_accum_ff     <= node_accum_in;
         dropped_ff        <= dropped_in;
      end
   end

   a_new_conn_clears: assert property (@(posedge clock) disable iff (reset)
      step && item.command == lpfp_pkg::CMD_NEW_CONN |=>
         phase_ff == lpfp_pkg::PHASE_HEADER && header_count_ff == 3'd0 && !dropped_ff)
      else $error("new connection did not clear parser state");

   a_dropped_in_header: assert property (@(posedge clock) disable iff (reset)
      dropped_ff |-> phase_ff == lpfp_pkg::PHASE_HEADER && header_count_ff == 3'd0)
      else $error("dropped stream left header or payload progress");

   a_dropped_silent: assert property (@(posedge clock) disable iff (reset)
      dropped_ff |-> !emit)
      else $error("result produced on a dropped stream");

   a_payload_no_header: assert property (@(posedge clock) disable iff (reset)
      phase_ff == lpfp_pkg::PHASE_PAYLOAD |-> header_count_ff == 3'd0)
      else $error("header count nonzero during payload");

   a_oversize_drops: assert property (@(posedge clock) disable iff (reset)
      emit && result.kind == lpfp_pkg::KIND_OVERSIZE |=> dropped_ff)
      else $error("oversize error did not drop the stream");

endmodule

/* sv/lpfp_out_reg.sv */
module lpfp_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  logic                 emit,
   input  lpfp_pkg::result_type result,
   output logic                 slot_free,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output lpfp_pkg::result_type rsp_result
);

   logic                 valid_ff, valid_in;
   lpfp_pkg::result_type result_ff;

   assign slot_free = !valid_ff || rsp_ready;

   always_comb begin
      if (load) begin
         valid_in = emit;
      end else begin
         valid_in = valid_ff && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && emit) begin
         result_ff <= result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

/* sv/length_prefixed_frame_parser.sv */
// Length-prefixed frame parser.
// The req channel carries one item per handshake: a command bit (received byte or
// new connection) and a stream byte. Frames are a 4-byte little-endian length, a
// type byte, then the payload. The rsp channel carries at most one result per item:
// a payload byte, an empty-frame mark, a heartbeat with its node id, or an oversize
// error, each with the frame's type and length and a last flag.
// The csr port writes the length limit (index 0) and heartbeat_type (index 1);
// write them only while no item is in flight.
// An item accepted at the req handshake lands in the input register; it is parsed
// and its result registered once the result register has room. Throughput is one
// item per cycle while the receiver does not stall, set by the combinational parse
// step between the input register and the result register.
// When the receiver stalls, the result register holds its item and the input
// register takes one more item; req_ready then drops until rsp_ready returns.
// An item waits in the input register while the result register is full, even
// when it yields no result.
// Reset restores the register defaults and the header phase; no clearing pass.
module length_prefixed_frame_parser (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_command,
   input  logic [lpfp_pkg::BYTE_W-1:0]         req_rx_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output lpfp_pkg::kind_type                  rsp_kind,
   output logic [lpfp_pkg::BYTE_W-1:0]         rsp_frame_type,
   output logic [lpfp_pkg::BYTE_W-1:0]         rsp_data_byte,
   output logic [lpfp_pkg::LEN_W-1:0]          rsp_node_id,
   output logic [lpfp_pkg::LEN_W-1:0]          rsp_frame_length,
   output logic                                rsp_last,
   input  logic                                csr_we,
   input  logic                                csr_index,
   input  logic [lpfp_pkg::LEN_W-1:0]          csr_wdata
);

   logic                 in_valid_ff, in_valid_in;
   lpfp_pkg::item_type   item_ff;
   logic                 advance;
   logic                 slot_free;
   logic                 emit;
   lpfp_pkg::result_type result;
   lpfp_pkg::result_type rsp_result;

   assign advance   = in_valid_ff && slot_free;
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.command <= req_command;
         item_ff.rx_byte <= req_rx_byte;
      end
   end

   lpfp_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .step      (advance),
      .item      (item_ff),
      .emit      (emit),
      .result    (result)
   );

   lpfp_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .emit       (emit),
      .result     (result),
      .slot_free  (slot_free),
      .rsp_ready  (rsp_ready),
      .rsp_valid  (rsp_valid),
      .rsp_result (rsp_result)
   );

   assign rsp_kind         = rsp_result.kind;
   assign rsp_frame_type   = rsp_result.frame_type;
   assign rsp_data_byte    = rsp_result.data_byte;
   assign rsp_node_id      = rsp_result.node_id;
   assign rsp_frame_length = rsp_result.frame_length;
   assign rsp_last         = rsp_result.last;

endmodule

/* dv/frame_parser_checker.sv */
`timescale 1ns / 1ps

module frame_parser_checker
   import lpfp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic              req_command,
   input  logic [BYTE_W-1:0] req_rx_byte,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  kind_type          rsp_kind,
   input  logic [BYTE_W-1:0] rsp_frame_type,
   input  logic [BYTE_W-1:0] rsp_data_byte,
   input  logic [LEN_W-1:0]  rsp_node_id,
   input  logic [LEN_W-1:0]  rsp_frame_length,
   input  logic              rsp_last,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [LEN_W-1:0]  csr_wdata,
   output int                errors,
   output int                outstanding
);

   localparam int REPORT_LIMIT = 100;

   logic [LEN_W-1:0]  max_len;
   logic [BYTE_W-1:0] hb_type;

   logic              phase;
   logic [2:0]        hdr_count;
   logic [LEN_W-1:0]  frame_len;
   logic [BYTE_W-1:0] frame_type_q;
   logic [LEN_W-1:0]  payload_seen;
   logic [LEN_W-1:0]  node_acc;
   logic              discarding;

   result_type        expected_q[$];

   initial errors = 0;

   function automatic void clear_parser();
      phase        = PHASE_HEADER;
      hdr_count    = '0;
      frame_len    = '0;
      frame_type_q = '0;
      payload_seen = '0;
      node_acc     = '0;
      discarding   = 1'b0;
   endfunction

   function automatic bit advance_parser(input item_type it, output result_type res);
      bit is_hb;
      res = '0;
      if (it.command == CMD_NEW_CONN) begin
         clear_parser();
         return 1'b0;
      end
      if (discarding)
         return 1'b0;
      if (phase == PHASE_HEADER) begin
         if (hdr_count < HEADER_LEN_BYTES) begin
            if (hdr_count == 0)
               frame_len = '0;
            frame_len = frame_len | (LEN_W'(it.rx_byte) << (8 * hdr_count));
            hdr_count = hdr_count + 1'b1;
            return 1'b0;
         end
         frame_type_q = it.rx_byte;
         hdr_count    = '0;
         payload_seen = '0;
         node_acc     = '0;
         res.frame_type   = frame_type_q;
         res.frame_length = frame_len;
         res.last         = 1'b1;
         if (frame_len > max_len) begin
            discarding = 1'b1;
            res.kind   = KIND_OVERSIZE;
            return 1'b1;
         end
         if (frame_len == 0) begin
            res.kind = (frame_type_q == hb_type) ? KIND_HEARTBEAT : KIND_EMPTY;
            return 1'b1;
         end
         phase = PHASE_PAYLOAD;
         return 1'b0;
      end
      is_hb = (frame_type_q == hb_type);
      if (payload_seen < NODE_ID_BYTES)
         node_acc = node_acc | (LEN_W'(it.rx_byte) << (8 * payload_seen));
      payload_seen = payload_seen + 1;
      res.frame_type   = frame_type_q;
      res.frame_length = frame_len;
      if (payload_seen >= frame_len) begin
         phase    = PHASE_HEADER;
         res.last = 1'b1;
         if (is_hb) begin
            res.kind    = KIND_HEARTBEAT;
            res.node_id = (frame_len >= NODE_ID_BYTES) ? node_acc : '0;
         end else begin
            res.kind      = KIND_PAYLOAD;
            res.data_byte = it.rx_byte;
         end
         return 1'b1;
      end
      if (is_hb)
         return 1'b0;
      res.kind      = KIND_PAYLOAD;
      res.data_byte = it.rx_byte;
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string field, input logic [LEN_W-1:0] got,
                                  input logic [LEN_W-1:0] want);
      if (errors < REPORT_LIMIT)
         $display("%0t: %s mismatch: got %0h, expected %0h", $time, field, got, want);
      errors++;
   endtask

   task automatic compare_result(input result_type got);
      result_type want;
      if (expected_q.size() == 0) begin
         report_mismatch("unexpected item, kind", LEN_W'(got.kind), '0);
         return;
      end
      want = expected_q.pop_front();
      if (got.kind !== want.kind)
         report_mismatch("kind", LEN_W'(got.kind), LEN_W'(want.kind));
      if (got.frame_type !== want.frame_type)
         report_mismatch("frame_type", LEN_W'(got.frame_type), LEN_W'(want.frame_type));
      if (got.data_byte !== want.data_byte)
         report_mismatch("data_byte", LEN_W'(got.data_byte), LEN_W'(want.data_byte));
      if (got.node_id !== want.node_id)
         report_mismatch("node_id", got.node_id, want.node_id);
      if (got.frame_length !== want.frame_length)
         report_mismatch("frame_length", got.frame_length, want.frame_length);
      if (got.last !== want.last)
         report_mismatch("last", LEN_W'(got.last), LEN_W'(want.last));
   endtask

   always @(posedge clock) begin
      item_type   in_item;
      result_type got;
      result_type predicted;
      if (reset) begin
         max_len = LEN_LIMIT_RESET;
         hb_type = HEARTBEAT_TYPE_RESET;
         clear_parser();
         expected_q.delete();
         outstanding <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.kind         = rsp_kind;
            got.frame_type   = rsp_frame_type;
            got.data_byte    = rsp_data_byte;
            got.node_id      = rsp_node_id;
            got.frame_length = rsp_frame_length;
            got.last         = rsp_last;
            compare_result(got);
         end
         if (req_valid && req_ready) begin
            in_item.command = req_command;
            in_item.rx_byte = req_rx_byte;
            if (advance_parser(in_item, predicted))
               expected_q = {expected_q, predicted};
         end
         if (csr_we) begin
            if (csr_index == CSR_LEN_LIMIT)
               max_len = csr_wdata;
            else
               hb_type = csr_wdata[BYTE_W-1:0];
         end
         outstanding <= expected_q.size();
      end
   end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import lpfp_pkg::*;

   localparam int ITEM_TARGET   = 1750;
   localparam int SETTLE_CYCLES = 4;
   localparam int STALL_LIMIT   = 2000;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_ready;
   logic              req_command = CMD_BYTE;
   logic [BYTE_W-1:0] req_rx_byte = '0;
   logic              rsp_valid;
   logic              rsp_ready   = 1'b0;
   kind_type          rsp_kind;
   logic [BYTE_W-1:0] rsp_frame_type;
   logic [BYTE_W-1:0] rsp_data_byte;
   logic [LEN_W-1:0]  rsp_node_id;
   logic [LEN_W-1:0]  rsp_frame_length;
   logic              rsp_last;
   logic              csr_we      = 1'b0;
   logic              csr_index   = CSR_LEN_LIMIT;
   logic [LEN_W-1:0]  csr_wdata   = '0;

   int                errors;
   int                outstanding;
   int                idle_pct     = 36;
   int                items_sent   = 0;
   int                quiet_cycles = 0;
   logic [LEN_W-1:0]  max_len      = LEN_LIMIT_RESET;
   logic [BYTE_W-1:0] hb_type      = HEARTBEAT_TYPE_RESET;

   length_prefixed_frame_parser u_dut (.*);

   frame_parser_checker u_checker (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= idle_pct);

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send_item(input logic cmd, input logic [BYTE_W-1:0] data, input bit counted);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_rx_byte <= data;
      do @(posedge clock); while (!req_ready);
      if (counted)
         items_sent++;
   endtask

   task automatic send_header(input logic [LEN_W-1:0] len, input logic [BYTE_W-1:0] ftype);
      for (int i = 0; i < 4; i++)
         send_item(CMD_BYTE, len[8*i +: 8], 1'b1);
      send_item(CMD_BYTE, ftype, 1'b1);
   endtask

   // an oversize header leaves the stream dropped; recover with a new connection
   task automatic send_frame(input logic [LEN_W-1:0] len, input logic [BYTE_W-1:0] ftype);
      send_header(len, ftype);
      if (len > max_len) begin
         repeat ($urandom_range(0, 2)) send_item(CMD_BYTE, 8'($urandom_range(255)), 1'b0);
         send_item(CMD_NEW_CONN, 8'($urandom_range(255)), 1'b1);
      end else begin
         repeat (len) send_item(CMD_BYTE, 8'($urandom_range(255)), 1'b1);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_config(input logic [LEN_W-1:0] new_max, input logic [BYTE_W-1:0] new_hb);
      wait_drained();
      csr_we    <= 1'b1;
      csr_index <= CSR_LEN_LIMIT;
      csr_wdata <= new_max;
      @(posedge clock);
      csr_index <= CSR_HEARTBEAT_TYPE;
      csr_wdata <= LEN_W'(new_hb);
      @(posedge clock);
      csr_we  <= 1'b0;
      max_len = new_max;
      hb_type = new_hb;
   endtask

   task automatic send_random_traffic();
      int unsigned      pick;
      logic [LEN_W-1:0] len;
      logic [BYTE_W-1:0] ftype;
      pick  = $urandom_range(99);
      ftype = ($urandom_range(99) < 30) ? hb_type : 8'($urandom_range(255));
      if (pick < 70) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 9);
         send_frame(len, ftype);
      end else if (pick < 80) begin
         // cut the header short
         repeat ($urandom_range(0, 4)) send_item(CMD_BYTE, 8'($urandom_range(255)), 1'b1);
         send_item(CMD_NEW_CONN, 8'($urandom_range(255)), 1'b1);
      end else if (pick < 92) begin
         len = $urandom();
         send_header(len, ftype);
         repeat ($urandom_range(0, 3))
            send_item(CMD_BYTE, 8'($urandom_range(255)), len <= max_len);
         send_item(CMD_NEW_CONN, 8'($urandom_range(255)), 1'b1);
      end else begin
         send_item(CMD_NEW_CONN, 8'($urandom_range(255)), 1'b1);
      end
   endtask

   task automatic run_traffic(input int target);
      while (items_sent < target) begin
         send_random_traffic();
         if ($urandom_range(49) == 0)
            wait_drained();
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_header(32'd0, 8'h5A);
      send_header(32'd0, HEARTBEAT_TYPE_RESET);
      send_header(32'd4, HEARTBEAT_TYPE_RESET);
      send_item(CMD_BYTE, 8'h01, 1'b1);
      send_item(CMD_BYTE, 8'hFF, 1'b1);
      send_item(CMD_BYTE, 8'h00, 1'b1);
      send_item(CMD_BYTE, 8'h80, 1'b1);
      send_header('1, 8'hFF);
      send_item(CMD_BYTE, 8'hFF, 1'b0);
      send_item(CMD_NEW_CONN, 8'h00, 1'b1);

      run_traffic(350);
      apply_config('0, 8'hFF);
      run_traffic(650);
      apply_config('1, 8'($urandom_range(255)));
      idle_pct = 0;
      run_traffic(1000);
      idle_pct = 36;
      apply_config($urandom_range(0, 16), 8'($urandom_range(255)));
      run_traffic(1350);
      apply_config(32'd8, HEARTBEAT_TYPE_RESET);
      run_traffic(ITEM_TARGET);
      wait_drained();

      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

/* length_prefixed_frame_parser.f */
sv/lpfp_pkg.sv
sv/lpfp_parse.sv
sv/lpfp_out_reg.sv
sv/length_prefixed_frame_parser.sv
dv/frame_parser_checker.sv
dv/testbench.sv
